@@ rtl/dic_pkg.sv @@
// Package: shared types, codes and constants for the double/int64 converter.
`timescale 1ns / 1ps
package dic_pkg;

  localparam int unsigned OpWidth   = 2;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned ExpBias   = 1023;

  typedef enum logic [1:0] {
    OP_D2S = 2'd0,
    OP_D2U = 2'd1,
    OP_S2D = 2'd2,
    OP_U2D = 2'd3
  } op_e;

  // Stage 1 to stage 2 bundle
  typedef struct packed {
    op_e         op;
    logic        neg;
    logic        is_float;
    logic        done;
    logic [63:0] fixed_res;
    logic        fixed_inv;
    logic [63:0] mag;
    logic [6:0]  shamt;
    logic        left;
  } s1_t;

  // Stage 2 to stage 3 bundle
  typedef struct packed {
    logic        neg;
    logic        is_float;
    logic        done;
    logic [63:0] fixed_res;
    logic        fixed_inv;
    logic [63:0] val;
    logic [5:0]  top;
    logic        zero;
  } s2_t;

  // Find the index of the highest set bit
  function automatic logic [5:0] lead_one(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

@@ rtl/dic_decode.sv @@
// Stage one: operand decode, special cases and shift setup.
`timescale 1ns / 1ps
module dic_decode (
  input  logic [dic_pkg::OpWidth-1:0]   op_i,
  input  logic [dic_pkg::DataWidth-1:0] x_i,
  output dic_pkg::s1_t                  s1_o
);
  import dic_pkg::*;

  logic        neg;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic        nan;

  assign neg  = x_i[63];
  assign bexp = x_i[62:52];
  assign frac = x_i[51:0];
  assign nan  = (bexp == 11'h7FF) && (frac != '0);

  // Classify the operation and settle saturating and zero-result cases
  always_comb begin
    s1_o           = '0;
    s1_o.op        = op_e'(op_i);
    s1_o.neg       = neg;
    s1_o.mag       = {11'd0, 1'b1, frac};
    unique case (op_e'(op_i))
      OP_D2S: begin
        if (nan) begin
          s1_o.done = 1'b1; s1_o.fixed_res = 64'h7FFF_FFFF_FFFF_FFFF; s1_o.fixed_inv = 1'b1;
        end else if (bexp >= 11'd1086) begin
          s1_o.done = 1'b1;
          s1_o.fixed_res = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          s1_o.fixed_inv = !(neg && bexp == 11'd1086 && frac == '0);
        end
      end
      OP_D2U: begin
        if (nan) begin
          s1_o.done = 1'b1; s1_o.fixed_res = '1; s1_o.fixed_inv = 1'b1;
        end else if (neg) begin
          s1_o.done = 1'b1;
        end else if (bexp > 11'd1086) begin
          s1_o.done = 1'b1; s1_o.fixed_res = '1; s1_o.fixed_inv = 1'b1;
        end
        s1_o.neg = 1'b0;
      end
      OP_S2D: begin
        s1_o.is_float = 1'b1;
        s1_o.mag      = neg ? (64'd0 - x_i) : x_i;
      end
      OP_U2D: begin
        s1_o.is_float = 1'b1;
        s1_o.neg      = 1'b0;
        s1_o.mag      = x_i;
      end
      default: ;
    endcase
    // Shift for truncation: below bias gives zero
    if (!s1_o.is_float) begin
      if (bexp < 11'(ExpBias)) begin
        s1_o.mag = '0;
      end else if (bexp >= 11'd1075) begin
        s1_o.left  = 1'b1;
        s1_o.shamt = 7'(bexp - 11'd1075);
      end else begin
        s1_o.shamt = 7'(11'd1075 - bexp);
      end
    end
  end

endmodule

@@ rtl/dic_shift.sv @@
// Stage two: truncation shift or leading-one detect.
`timescale 1ns / 1ps
module dic_shift (
  input  dic_pkg::s1_t s1_i,
  output dic_pkg::s2_t s2_o
);
  import dic_pkg::*;

  // Shift the significand or locate the top bit
  always_comb begin
    s2_o           = '0;
    s2_o.neg       = s1_i.neg;
    s2_o.is_float  = s1_i.is_float;
    s2_o.done      = s1_i.done;
    s2_o.fixed_res = s1_i.fixed_res;
    s2_o.fixed_inv = s1_i.fixed_inv;
    s2_o.zero      = (s1_i.mag == '0);
    if (s1_i.is_float) begin
      s2_o.val = s1_i.mag;
      s2_o.top = lead_one(s1_i.mag);
    end else if (s1_i.left) begin
      s2_o.val = s1_i.mag << s1_i.shamt[5:0];
    end else begin
      s2_o.val = s1_i.mag >> s1_i.shamt[5:0];
    end
  end

endmodule

@@ rtl/dic_round.sv @@
// Stage three: rounding, packing and final sign.
`timescale 1ns / 1ps
module dic_round (
  input  dic_pkg::s2_t s2_i,
  output logic [63:0]  res_o,
  output logic         inv_o
);
  import dic_pkg::*;

  logic [63:0] norm;
  logic [52:0] keep;
  logic [10:0] rest;
  logic        rnd;
  logic [53:0] sum;
  logic [10:0] bexp;

  // Normalize so the top bit sits at bit 63, then round to 53 bits
  always_comb begin
    norm = s2_i.val << (6'd63 - s2_i.top);
    keep = norm[63:11];
    rest = norm[10:0];
    rnd  = rest[10] && ((rest[9:0] != '0) || keep[0]);
    sum  = {1'b0, keep} + 54'(rnd);
    bexp = 11'(ExpBias) + 11'(s2_i.top) + 11'(sum[53]);
    inv_o = 1'b0;
    if (s2_i.done) begin
      res_o = s2_i.fixed_res;
      inv_o = s2_i.fixed_inv;
    end else if (s2_i.is_float) begin
      if (s2_i.zero) res_o = '0;
      else res_o = {s2_i.neg, bexp, sum[53] ? sum[52:1] : sum[51:0]};
    end else begin
      res_o = s2_i.neg ? (64'd0 - s2_i.val) : s2_i.val;
    end
  end

endmodule

@@ rtl/double_int64_converter_core.sv @@
// Top level: three-stage pipelined double/int64 converter with stream ports.
// Decode, shift and round stage registers lie between input transfer and result valid.
// Throughput: one transfer per cycle; a stalled output freezes every stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// Stages: decode and 64-bit negate, shift or leading-one search, normalize and round.
`timescale 1ns / 1ps
module double_int64_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata: [63:0] operand
  input  logic [dic_pkg::DataWidth-1:0] s_axis_tdata_i,
  // tuser: [1:0] operation
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata: [63:0] result
  output logic [dic_pkg::DataWidth-1:0] m_axis_tdata_o,
  // tuser: [0] invalid
  output logic          m_axis_tuser_o
);
  import dic_pkg::*;

  logic         adv;
  logic         v1_q, v2_q, v3_q;
  s1_t          s1_d, s1_q;
  s2_t          s2_d, s2_q;
  logic [63:0]  res_d, res_q;
  logic         inv_d, inv_q;

  // Advance whenever the output slot is empty or drains
  assign adv             = !v3_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  dic_decode u_dec (.op_i(s_axis_tuser_i), .x_i(s_axis_tdata_i), .s1_o(s1_d));
  dic_shift  u_sh  (.s1_i(s1_q), .s2_o(s2_d));
  dic_round  u_rnd (.s2_i(s2_q), .res_o(res_d), .inv_o(inv_d));

  // Hold valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d; s2_q <= s2_d; res_q <= res_d; inv_q <= inv_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = inv_q;

  // Stalled result must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && m_axis_tvalid_o)
    else $error("result changed under stall");
  // Invalid only comes with a saturated result
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 64'h7FFF_FFFF_FFFF_FFFF
      || m_axis_tdata_o == 64'h8000_0000_0000_0000 || m_axis_tdata_o == '1)
    else $error("invalid flag without saturated result");
  // Input accepted flows to stage one
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v1_q)
    else $error("accepted item lost");

endmodule
